>>> hdl/fsg_pkg.sv
package fsg_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    // outcome of one grain decision
    typedef struct packed {
        logic move;
        dir_t dir;
    } move_t;

endpackage

>>> hdl/fsg_cell_unit.sv
module fsg_cell_unit (
    input  logic          grain,
    input  logic          below_left,
    input  logic          below_mid,
    input  logic          below_right,
    input  logic          has_left,
    input  logic          has_right,
    output fsg_pkg::move_t decision
);
    import fsg_pkg::*;

    always_comb
    begin
        decision.move = 1'b0;
        decision.dir  = DIR_DOWN;
        if (grain)
        begin
            if (!below_mid)
            begin
                decision.move = 1'b1;
                decision.dir  = DIR_DOWN;
            end
            else if (has_left && !below_left)
            begin
                decision.move = 1'b1;
                decision.dir  = DIR_LEFT;
            end
            else if (has_right && !below_right)
            begin
                decision.move = 1'b1;
                decision.dir  = DIR_RIGHT;
            end
        end
    end

endmodule

>>> hdl/falling_sand_grid_step_core.sv
// Place, erase, read: the row is read (S_RD), updated and written back (S_MOD), result held in S_OUT.
// Tick: rows scanned from the bottom row up, one cell
// per cycle through the shared grain decision unit, one row memory port each way.
// One request at a time: ready again once the result has been taken.
// After reset (rst_n async, active low) a clearing pass writes every row to air
// before the first request is taken.
module falling_sand_grid_step_core #(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cmd[1:0], row[7:2], column[13:8], zero fill
    input  logic [fsg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // cell_value[0], zero fill
    output logic [fsg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import fsg_pkg::*;

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLUMNS);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_RD      = 11'b000_0000_0100,
        S_MOD     = 11'b000_0000_1000,
        S_OUT     = 11'b000_0001_0000,
        S_T_START = 11'b000_0010_0000,
        S_T_BELOW = 11'b000_0100_0000,
        S_T_CUR   = 11'b000_1000_0000,
        S_T_SCAN  = 11'b001_0000_0000,
        S_T_WB    = 11'b010_0000_0000,
        S_T_TOP   = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    cmd_t                cmd_reg, cmd_next;
    logic                value_reg, value_next;
    logic [GRID_COLUMNS-1:0] below_reg, below_next;
    logic [GRID_COLUMNS-1:0] cur_reg, cur_next;

    // row memory
    logic [GRID_COLUMNS-1:0] mem [GRID_ROWS];
    logic [GRID_COLUMNS-1:0] rd_data_reg;
    logic                    rd_en, wr_en;
    logic [RW-1:0]           rd_addr, wr_addr;
    logic [GRID_COLUMNS-1:0] wr_data;

    // input fields
    cmd_t        in_cmd;
    logic [31:0] in_row_ext, in_col_ext;
    logic        in_inside;

    // scan datapath
    logic        has_left, has_right;
    logic [CW-1:0] col_m1, col_p1;
    logic        b_left, b_right;
    move_t       decision;
    logic [GRID_COLUMNS-1:0] rmw_row;

    assign in_cmd     = cmd_t'(s_axis_tdata[1:0]);
    assign in_row_ext = 32'(s_axis_tdata[7:2]);
    assign in_col_ext = 32'(s_axis_tdata[13:8]);
    assign in_inside  = (in_row_ext < 32'(GRID_ROWS)) && (in_col_ext < 32'(GRID_COLUMNS));

    assign has_left  = (col_reg != '0);
    assign has_right = (col_reg != CW'(GRID_COLUMNS - 1));
    assign col_m1    = col_reg - CW'(1);
    assign col_p1    = col_reg + CW'(1);
    assign b_left    = has_left  ? below_reg[col_m1] : 1'b1;
    assign b_right   = has_right ? below_reg[col_p1] : 1'b1;

    fsg_cell_unit u_cell (
        .grain       (cur_reg[col_reg]),
        .below_left  (b_left),
        .below_mid   (below_reg[col_reg]),
        .below_right (b_right),
        .has_left    (has_left),
        .has_right   (has_right),
        .decision    (decision)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, value_reg};

    always_comb
    begin
        rmw_row = rd_data_reg;
        case (cmd_reg)
            CMD_PLACE: rmw_row[col_reg] = 1'b1;
            CMD_ERASE: rmw_row[col_reg] = 1'b0;
            default:   rmw_row = rd_data_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd_next   = cmd_reg;
        value_next = value_reg;
        below_next = below_reg;
        cur_next   = cur_reg;
        rd_en      = 1'b0;
        rd_addr    = row_reg;
        wr_en      = 1'b0;
        wr_addr    = row_reg;
        wr_data    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = row_reg;
                wr_data = '0;
                row_next = row_reg + RW'(1);
                if (row_reg == RW'(GRID_ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = in_cmd;
                    row_next   = in_row_ext[RW-1:0];
                    col_next   = in_col_ext[CW-1:0];
                    value_next = 1'b0;
                    if (in_cmd == CMD_TICK)
                        state_next = S_T_START;
                    else if (in_inside)
                        state_next = S_RD;
                    else
                        state_next = S_OUT;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = row_reg;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                wr_en      = 1'b1;
                wr_addr    = row_reg;
                wr_data    = rmw_row;
                value_next = rmw_row[col_reg];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            S_T_START:
            begin
                rd_en      = 1'b1;
                rd_addr    = RW'(GRID_ROWS - 1);
                state_next = S_T_BELOW;
            end
            S_T_BELOW:
            begin
                below_next = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = RW'(GRID_ROWS - 2);
                row_next   = RW'(GRID_ROWS - 2);
                state_next = S_T_CUR;
            end
            S_T_CUR:
            begin
                cur_next   = rd_data_reg;
                col_next   = '0;
                state_next = S_T_SCAN;
            end
            S_T_SCAN:
            begin
                if (decision.move)
                begin
                    cur_next[col_reg] = 1'b0;
                    case (decision.dir)
                        DIR_LEFT:  below_next[col_m1]  = 1'b1;
                        DIR_RIGHT: below_next[col_p1]  = 1'b1;
                        default:   below_next[col_reg] = 1'b1;
                    endcase
                end
                col_next = col_p1;
                if (!has_right)
                    state_next = S_T_WB;
            end
            S_T_WB:
            begin
                // row below is final now; the scanned row becomes the next one's floor
                wr_en      = 1'b1;
                wr_addr    = row_reg + RW'(1);
                wr_data    = below_reg;
                below_next = cur_reg;
                if (row_reg == '0)
                    state_next = S_T_TOP;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = row_reg - RW'(1);
                    row_next   = row_reg - RW'(1);
                    state_next = S_T_CUR;
                end
            end
            S_T_TOP:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = below_reg;
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        cmd_reg   <= cmd_next;
        value_reg <= value_next;
        below_reg <= below_next;
        cur_reg   <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> hdl/fsg_checker.sv
module fsg_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [fsg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [fsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import fsg_pkg::*;

    logic in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // one request in flight: never ready while a result is pending
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready while result pending");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("ready straight after request taken");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |=> s_axis_tready && !m_axis_tvalid)
        else $error("not ready after result taken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:1] == '0)
        else $error("result fill bits set");

endmodule

bind falling_sand_grid_step_core fsg_checker u_fsg_checker (.*);

>>> sim/falling_sand_grid_step_core_test.sv
module falling_sand_grid_step_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fsg_pkg::*;

    localparam int GRID_COLUMNS = 64;
    localparam int GRID_ROWS    = 64;
    localparam int RANDOM_ITEMS = 116;
    localparam int TAIL_ITEMS   = 20;
    localparam int CYCLE_LIMIT  = 3_000_000;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // requests still to be sent, and cell values still to come back
    logic [IN_TDATA_W-1:0]  req_q[$];
    bit                     cell_due_q[$];
    bit                     sand_map[GRID_ROWS][GRID_COLUMNS];

    logic                   tail_phase = 1'b0;
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     cmd_seen[4] = '{0, 0, 0, 0};
    int                     sand_reads = 0;

    falling_sand_grid_step_core #(
        .GRID_COLUMNS(GRID_COLUMNS),
        .GRID_ROWS   (GRID_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // one update pass: bottom row up, left to right within a row
    function automatic void settle_sand();
        for (int r = GRID_ROWS - 2; r >= 0; r--)
        begin
            for (int c = 0; c < GRID_COLUMNS; c++)
            begin
                if (sand_map[r][c])
                begin
                    if (!sand_map[r + 1][c])
                    begin
                        sand_map[r][c]     = 1'b0;
                        sand_map[r + 1][c] = 1'b1;
                    end
                    else if (c > 0 && !sand_map[r + 1][c - 1])
                    begin
                        sand_map[r][c]         = 1'b0;
                        sand_map[r + 1][c - 1] = 1'b1;
                    end
                    else if (c < GRID_COLUMNS - 1 && !sand_map[r + 1][c + 1])
                    begin
                        sand_map[r][c]         = 1'b0;
                        sand_map[r + 1][c + 1] = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic bit apply_request(logic [IN_TDATA_W-1:0] req);
        cmd_t     cmd;
        int       r;
        int       c;
        bit       value;
        cmd   = cmd_t'(req[1:0]);
        r     = int'(req[7:2]);
        c     = int'(req[13:8]);
        value = 1'b0;
        if (cmd == CMD_TICK)
            settle_sand();
        else if (r < GRID_ROWS && c < GRID_COLUMNS)
        begin
            if (cmd == CMD_PLACE)
                sand_map[r][c] = 1'b1;
            else if (cmd == CMD_ERASE)
                sand_map[r][c] = 1'b0;
            value = sand_map[r][c];
        end
        return value;
    endfunction

    task automatic push_req(cmd_t cmd, int r, int c);
        logic [5:0] r6;
        logic [5:0] c6;
        r6 = r[5:0];
        c6 = c[5:0];
        req_q.push_back({2'b00, c6, r6, cmd});
    endtask

    // request side
    always @(posedge clk or negedge rst_n)
    begin
        int                    src_gap;
        logic                  next_valid;
        logic [IN_TDATA_W-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                cell_due_q.push_back(apply_request(s_axis_tdata));
                cmd_seen[s_axis_tdata[1:0]]++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (req_q.size() > 0)
                begin
                    next_data  = req_q.pop_front();
                    next_valid = 1'b1;
                    if (req_q.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 15);
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
            tail_phase    <= (req_q.size() < TAIL_ITEMS);
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin
        int  snk_gap;
        bit  want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cell_due_q.size() == 0)
                begin
                    $error("result with no request outstanding: cell_value=%0d",
                           m_axis_tdata[0]);
                    error_count++;
                end
                else
                begin
                    want = cell_due_q.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        $error("cell_value mismatch: expected %0d, got %0d",
                               want, m_axis_tdata[0]);
                        error_count++;
                    end
                    else if (want)
                        sand_reads++;
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 5) == 0)
                    snk_gap = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int n_random;
        int burst;
        int win_r;
        int win_c;

        // directed: corners, erase, ignored tick fields, edge diagonals
        push_req(CMD_PLACE, 0, 0);
        push_req(CMD_READ, 0, 0);
        push_req(CMD_PLACE, 63, 63);
        push_req(CMD_READ, 63, 63);
        push_req(CMD_PLACE, 0, 63);
        push_req(CMD_ERASE, 0, 63);
        push_req(CMD_READ, 0, 63);
        push_req(CMD_TICK, 63, 63);
        push_req(CMD_READ, 1, 0);
        push_req(CMD_PLACE, 62, 63);
        push_req(CMD_PLACE, 61, 63);
        push_req(CMD_TICK, 0, 0);
        push_req(CMD_READ, 63, 62);
        push_req(CMD_READ, 62, 63);
        push_req(CMD_PLACE, 63, 0);
        push_req(CMD_PLACE, 62, 0);
        push_req(CMD_TICK, 42, 21);
        push_req(CMD_READ, 63, 1);
        push_req(CMD_READ, 62, 0);
        push_req(CMD_PLACE, 62, 63);
        push_req(CMD_TICK, 21, 42);
        push_req(CMD_READ, 62, 63);
        push_req(CMD_ERASE, 63, 63);
        push_req(CMD_READ, 63, 63);

        // random: mostly small piles dropped and settled, some scattered noise
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 2))
                    0:       win_c = 0;
                    1:       win_c = GRID_COLUMNS - 4;
                    default: win_c = $urandom_range(1, GRID_COLUMNS - 5);
                endcase
                if ($urandom_range(0, 3) == 0)
                    win_r = $urandom_range(0, GRID_ROWS - 6);
                else
                    win_r = $urandom_range(GRID_ROWS - 12, GRID_ROWS - 6);
                burst = $urandom_range(3, 6);
                repeat (burst)
                    push_req(CMD_PLACE, win_r + $urandom_range(0, 3),
                             win_c + $urandom_range(0, 3));
                n_random += burst;
                if ($urandom_range(0, 2) == 0)
                begin
                    push_req(CMD_ERASE, win_r + $urandom_range(0, 5),
                             win_c + $urandom_range(0, 3));
                    n_random++;
                end
                burst = $urandom_range(1, 3);
                repeat (burst)
                    push_req(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 63));
                n_random += burst;
                burst = $urandom_range(2, 4);
                repeat (burst)
                    push_req(CMD_READ, win_r + $urandom_range(0, 5),
                             win_c + $urandom_range(0, 3));
                n_random += burst;
            end
            else
            begin
                push_req(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                         $urandom_range(0, 63));
                n_random++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (req_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (cell_due_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Requests: %0d place, %0d erase, %0d tick, %0d read",
                 cmd_seen[CMD_PLACE], cmd_seen[CMD_ERASE], cmd_seen[CMD_TICK],
                 cmd_seen[CMD_READ]);
        $display("Results returning sand: %0d, errors: %0d", sand_reads, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/fsg_pkg.sv
hdl/fsg_cell_unit.sv
hdl/falling_sand_grid_step_core.sv
hdl/fsg_checker.sv
sim/falling_sand_grid_step_core_test.sv
